/* sv/pcm_pkg.sv */
// Shared types, constants and tables for the phase coherence magnitude unit.
package pcm_pkg;

   localparam int PHASE_W       = 16;
   localparam int COH_W         = 17;
   localparam int COUNT_W       = 13;
   localparam int ANGLE_BITS    = 16;
   localparam int MAX_ITEMS_DEF = 4096;
   localparam int CORDIC_STEPS  = 24;
   localparam int CORDIC_W      = 33;
   localparam int TRIG_W        = 18;
   localparam int STEP_W        = 5;
   localparam logic [COH_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
      logic                     last;
   } trig_word_type;

   function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
      logic signed [CORDIC_W-1:0] r;
      unique case (idx)
         5'd0:  r = 33'sd536870912;
         5'd1:  r = 33'sd316933406;
         5'd2:  r = 33'sd167458907;
         5'd3:  r = 33'sd85004756;
         5'd4:  r = 33'sd42667331;
         5'd5:  r = 33'sd21354465;
         5'd6:  r = 33'sd10679838;
         5'd7:  r = 33'sd5340245;
         5'd8:  r = 33'sd2670163;
         5'd9:  r = 33'sd1335087;
         5'd10: r = 33'sd667544;
         5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;
         5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;
         5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;
         5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;
         5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;
         5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;
         5'd23: r = 33'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Clamp to [0, 1.0] in Q30, round to Q16.
   function automatic logic [COH_W-1:0] to_q16(input logic signed [CORDIC_W-1:0] v);
      logic [30:0] c;
      logic [31:0] r;
      if (v < 0) begin
         c = '0;
      end else if (v > 33'sd1073741824) begin
         c = 31'd1073741824;
      end else begin
         c = v[30:0];
      end
      r = ({1'b0, c} + 32'd8192) >> 14;
      return (r > 32'd65536) ? ONE_Q16 : r[COH_W-1:0];
   endfunction

endpackage

/* sv/pcm_if.sv */
// Handshake channels for phase words and coherence results.
interface pcm_req_if;
   import pcm_pkg::*;
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic               last;
   modport source (output valid, phase, last, input ready);
   modport sink   (input valid, phase, last, output ready);
endinterface

interface pcm_rsp_if;
   import pcm_pkg::*;
   logic               valid;
   logic               ready;
   logic [COH_W-1:0]   coherence;
   logic [COUNT_W-1:0] count;
   logic               overflow;
   modport source (output valid, coherence, count, overflow, input ready);
   modport sink   (input valid, coherence, count, overflow, output ready);
endinterface

/* sv/phase_coherence_magnitude_unit.sv */
// Top level of the phase coherence magnitude unit.
// Computes the Kuramoto order parameter |mean(exp(j*phase))| over a run of phases.
// req_ch carries one phase word (16-bit fraction of a turn) and a last flag per
// valid/ready transfer. rsp_ch carries one result word per run: coherence
// (Q16, 65536 = 1.0), the count of phases summed and an overflow flag set when
// phases beyond MAX_ITEMS were dropped.
// In the front end each phase is loaded, takes 24 CORDIC steps on a shared
// shift-add unit and is pushed into a two-entry queue, waiting while it is full;
// the front end takes one phase at a time. The back end adds one queued word per
// cycle while idle and not held by a stalled result. After a last word it squares
// the sums, takes an HW-bit square root (HW = clog2(MAX_ITEMS+1)+17, 30 by
// default) and divides by the count, then holds the result in an output register.
// A stalled result blocks only the next last word; accumulation continues.
// Synchronous reset clears the sums, count, queue and output valid.
module phase_coherence_magnitude_unit
   import pcm_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pcm_req_if.sink   req_ch,
   pcm_rsp_if.source rsp_ch
);
   logic          f_valid, f_ready, b_valid, b_ready;
   trig_word_type f_word, b_word;

   pcm_front u_front (
      .clock, .reset, .req_ch,
      .push_valid(f_valid), .push_ready(f_ready), .push_word(f_word)
   );

   pcm_queue u_queue (
      .clock, .reset,
      .push_valid(f_valid), .push_ready(f_ready), .push_word(f_word),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_word(b_word)
   );

   pcm_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
      .clock, .reset,
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_word(b_word), .rsp_ch
   );
endmodule

/* sv/pcm_front.sv */
// Front end: accepts phase words and turns each into cosine and sine by CORDIC.
module pcm_front
   import pcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pcm_req_if.sink       req_ch,
   output logic          push_valid,
   input  logic          push_ready,
   output trig_word_type push_word
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;
   localparam int DROP = (ANGLE_BITS < PHASE_W) ? (PHASE_W - ANGLE_BITS) : 0;

   logic [1:0]                 state_ff, state_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [STEP_W-1:0]          i_ff, i_in;
   logic [1:0]                 quad_ff, quad_in;
   logic                       last_ff, last_in;
   logic [PHASE_W-1:0]         p;
   logic signed [CORDIC_W-1:0] dx, dy, at;
   logic [COH_W-1:0]           cq, sq;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign p  = (req_ch.phase >> DROP) << DROP;
   assign dx = y_ff >>> i_ff;
   assign dy = x_ff >>> i_ff;
   assign at = atan_step(i_ff);
   assign cq = to_q16(x_ff);
   assign sq = to_q16(y_ff);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      quad_in = quad_ff; last_in = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               x_in = CORDIC_X0;
               y_in = '0;
               z_in = {3'b000, p[PHASE_W-3:0], 16'h0000};
               i_in = '0;
               quad_in = p[PHASE_W-1:PHASE_W-2];
               last_in = req_ch.last;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (push_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      push_word.last = last_ff;
      unique case (quad_ff)
         2'd0: begin
            push_word.cos_val = $signed({1'b0, cq});  push_word.sin_val = $signed({1'b0, sq});
         end
         2'd1: begin
            push_word.cos_val = -$signed({1'b0, sq}); push_word.sin_val = $signed({1'b0, cq});
         end
         2'd2: begin
            push_word.cos_val = -$signed({1'b0, cq}); push_word.sin_val = -$signed({1'b0, sq});
         end
         default: begin
            push_word.cos_val = $signed({1'b0, sq});  push_word.sin_val = -$signed({1'b0, cq});
         end
      endcase
   end
   assign push_valid = (state_ff == S_PUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      quad_ff <= quad_in; last_ff <= last_in;
   end
endmodule

/* sv/pcm_queue.sv */
// Two-entry queue between front and back end.
module pcm_queue
   import pcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  trig_word_type push_word,
   output logic          pop_valid,
   input  logic          pop_ready,
   output trig_word_type pop_word
);
   trig_word_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_word   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) mem_ff[wr_ff] <= push_word;
   end
endmodule

/* sv/pcm_back.sv */
// Back end: accumulates, then square root and divide for each run.
module pcm_back
   import pcm_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  trig_word_type pop_word,
   pcm_rsp_if.source     rsp_ch
);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = CW + 18;
   localparam int HW = SW - 1;
   localparam int RW = 2 * HW;
   localparam int NW = $clog2(HW + 2);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQC  = 3'd1;
   localparam logic [2:0] S_SQS  = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;

   logic [2:0]           state_ff;
   logic signed [SW-1:0] csum_ff, ssum_ff, csum_n, ssum_n;
   logic [CW-1:0]        cnt_ff, run_cnt_ff;
   logic                 drop_ff, run_drop_ff, has_room;
   logic [HW-1:0]        ac_ff, as_ff, root_ff;
   logic [RW-1:0]        prod_ff, rad_ff;
   logic [HW:0]          rem_ff, dvd_ff, quo_ff;
   logic [CW:0]          drem_ff;
   logic [NW-1:0]        step_ff;
   logic [COH_W-1:0]     coh_ff;
   logic [COUNT_W-1:0]   ocnt_ff;
   logic                 ovf_ff, vld_ff;
   logic [HW+1:0]        rem_t, trial;
   logic [CW:0]          drem_t;
   logic                 qbit;
   logic [HW:0]          quo_n;

   assign pop_ready = (state_ff == S_IDLE) && !(pop_word.last && vld_ff);
   assign has_room  = (CW+1)'(cnt_ff) < (CW+1)'(MAX_ITEMS);
   assign csum_n = has_room ? csum_ff + SW'(pop_word.cos_val) : csum_ff;
   assign ssum_n = has_room ? ssum_ff + SW'(pop_word.sin_val) : ssum_ff;

   assign rem_t  = {rem_ff[HW-1:0], rad_ff[RW-1:RW-2]};
   assign trial  = {root_ff, 2'b01};
   assign drem_t = {drem_ff[CW-1:0], dvd_ff[HW]};
   assign qbit   = drem_t >= {1'b0, run_cnt_ff};
   assign quo_n  = {quo_ff[HW-1:0], qbit};

   assign rsp_ch.valid     = vld_ff;
   assign rsp_ch.coherence = coh_ff;
   assign rsp_ch.count     = ocnt_ff;
   assign rsp_ch.overflow  = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         csum_ff <= '0; ssum_ff <= '0; cnt_ff <= '0; drop_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) vld_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid && pop_ready) begin
                  if (pop_word.last) begin
                     // hand the run to the math steps and clear for the next one
                     ac_ff <= csum_n[SW-1] ? HW'(-csum_n) : HW'(csum_n);
                     as_ff <= ssum_n[SW-1] ? HW'(-ssum_n) : HW'(ssum_n);
                     run_cnt_ff  <= has_room ? cnt_ff + 1'b1 : cnt_ff;
                     run_drop_ff <= drop_ff || !has_room;
                     csum_ff <= '0; ssum_ff <= '0; cnt_ff <= '0; drop_ff <= 1'b0;
                     state_ff <= S_SQC;
                  end else begin
                     csum_ff <= csum_n; ssum_ff <= ssum_n;
                     if (has_room) cnt_ff <= cnt_ff + 1'b1;
                     else drop_ff <= 1'b1;
                  end
               end
            end
            S_SQC: begin
               prod_ff  <= RW'(ac_ff) * RW'(ac_ff);
               state_ff <= S_SQS;
            end
            S_SQS: begin
               rad_ff   <= prod_ff + RW'(as_ff) * RW'(as_ff);
               rem_ff   <= '0;
               root_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               rad_ff <= rad_ff << 2;
               if (rem_t >= trial) begin
                  rem_ff  <= (HW+1)'(rem_t - trial);
                  root_ff <= {root_ff[HW-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_t[HW:0];
                  root_ff <= {root_ff[HW-2:0], 1'b0};
               end
               if (step_ff == NW'(HW - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_DIV;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DIV: begin
               if (step_ff == '0) begin
                  // root is final here; add half the count for rounding
                  dvd_ff  <= {1'b0, root_ff} + (HW+1)'(run_cnt_ff >> 1);
                  drem_ff <= '0;
                  quo_ff  <= '0;
                  step_ff <= NW'(1);
               end else begin
                  dvd_ff  <= dvd_ff << 1;
                  drem_ff <= qbit ? drem_t - {1'b0, run_cnt_ff} : drem_t;
                  quo_ff  <= quo_n;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == NW'(HW + 1)) begin
                     if (run_cnt_ff == '0) coh_ff <= '0;
                     else if (quo_n > (HW+1)'(ONE_Q16)) coh_ff <= ONE_Q16;
                     else coh_ff <= COH_W'(quo_n);
                     ocnt_ff  <= COUNT_W'(run_cnt_ff);
                     ovf_ff   <= run_drop_ff;
                     vld_ff   <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* sv/pcm_checker.sv */
// Port-level checks for the phase coherence magnitude unit, bound to the top level.
module pcm_checker
   import pcm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COH_W-1:0]   rsp_coherence,
   input logic [COUNT_W-1:0] rsp_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coherence))
      else $error("result word dropped or changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coherence <= ONE_Q16)
      else $error("coherence above 1.0");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != '0)
      else $error("result word with empty run");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind phase_coherence_magnitude_unit pcm_checker u_pcm_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_coherence(rsp_ch.coherence),
   .rsp_count(rsp_ch.count)
);

/* tb/pcm_coherence_check.sv */
// Watches both channels of the coherence unit, predicts every result and compares it.
module pcm_coherence_check
   import pcm_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   pcm_req_if    req,
   pcm_rsp_if    rsp,
   output int    fail_count,
   output int    pending,
   output int    results_seen
);

   typedef struct {
      logic [COH_W-1:0]   coherence;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } coh_result_type;

   localparam longint ROT_X0 = 64'sd652032874;

   coh_result_type expected_results[$];
   longint      cos_acc;
   longint      sin_acc;
   int unsigned phase_count;
   bit          dropped;

   function automatic longint rot_angle(input int i);
      longint turns[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                            21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                            1304, 652, 326, 163, 81};
      return turns[i];
   endfunction

   function automatic longint q30_to_q16(input longint v);
      longint r;
      r = v;
      if (r < 0) r = 0;
      if (r > (64'sd1 << 30)) r = 64'sd1 << 30;
      r = (r + 8192) >>> 14;
      if (r > 65536) r = 65536;
      return r;
   endfunction

   // Rotation-mode CORDIC on the angle within the quadrant, then fold by quadrant.
   task automatic phase_trig(input logic [PHASE_W-1:0] ph, output longint c_out,
                             output longint s_out);
      logic [31:0] turn;
      longint      x, y, z, dx, dy, c, s;
      turn = {ph, 16'h0000};
      x = ROT_X0;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= rot_angle(i);
         end else begin
            x += dx; y -= dy; z += rot_angle(i);
         end
      end
      c = q30_to_q16(x);
      s = q30_to_q16(y);
      case (turn[31:30])
         2'd0: begin c_out = c;  s_out = s;  end
         2'd1: begin c_out = -s; s_out = c;  end
         2'd2: begin c_out = -c; s_out = -s; end
         default: begin c_out = s; s_out = -c; end
      endcase
   endtask

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned rem, res, bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   task automatic absorb_phase(input logic [PHASE_W-1:0] ph, input logic is_last);
      longint      c, s, ac, as_, m, coh;
      coh_result_type r;
      if (phase_count < MAX_ITEMS) begin
         phase_trig(ph, c, s);
         cos_acc += c;
         sin_acc += s;
         phase_count++;
      end else begin
         dropped = 1'b1;
      end
      if (is_last) begin
         coh = 0;
         if (phase_count != 0) begin
            ac = (cos_acc < 0) ? -cos_acc : cos_acc;
            as_ = (sin_acc < 0) ? -sin_acc : sin_acc;
            m = int_sqrt(longint'(ac * ac + as_ * as_));
            coh = (m + phase_count / 2) / phase_count;
            if (coh > 65536) coh = 65536;
         end
         r.coherence = coh[COH_W-1:0];
         r.count     = phase_count[COUNT_W-1:0];
         r.overflow  = dropped;
         expected_results.push_back(r);
         cos_acc = 0;
         sin_acc = 0;
         phase_count = 0;
         dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      coh_result_type e;
      if (reset) begin
         cos_acc = 0;
         sin_acc = 0;
         phase_count = 0;
         dropped = 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: coherence %0d count %0d overflow %0d",
                           rsp.coherence, rsp.count, rsp.overflow);
            end else begin
               e = expected_results.pop_front();
               if (e.coherence !== rsp.coherence || e.count !== rsp.count
                   || e.overflow !== rsp.overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected coh %0d cnt %0d ovf %0d, got %0d %0d %0d",
                              e.coherence, e.count, e.overflow,
                              rsp.coherence, rsp.count, rsp.overflow);
               end
            end
         end
         if (req.valid && req.ready)
            absorb_phase(req.phase, req.last);
      end
      pending = expected_results.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
   end

endmodule

/* tb/phase_coherence_magnitude_unit_tb.sv */
// Stimulus, clock, reset and verdict for the phase coherence magnitude unit.
module phase_coherence_magnitude_unit_tb;
   import pcm_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, results_seen;
   int   cycle_count = 0;
   int   rsp_hold = 0;
   bit   idle_on = 1'b1;
   int   words_sent = 0;

   pcm_req_if req_ch ();
   pcm_rsp_if rsp_ch ();

   phase_coherence_magnitude_unit uut (
      .clock (clock), .reset (reset), .req_ch (req_ch), .rsp_ch (rsp_ch)
   );

   pcm_coherence_check chk (
      .clock (clock), .reset (reset), .req (req_ch), .rsp (rsp_ch),
      .fail_count (fail_count), .pending (pending), .results_seen (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ch.ready <= idle_on ? ($urandom_range(99) >= 8) : 1'b1;
      end
   end

   task automatic send_word(input logic [PHASE_W-1:0] ph, input logic lst);
      if (idle_on && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.phase <= ph;
      req_ch.last  <= lst;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      words_sent++;
   endtask

   task automatic send_run(input int len, input logic [PHASE_W-1:0] center,
                           input int spread);
      logic [PHASE_W-1:0] ph;
      for (int i = 0; i < len; i++) begin
         ph = (spread < 0) ? PHASE_W'($urandom)
                           : center + PHASE_W'($urandom_range(2 * spread) - spread);
         send_word(ph, i == len - 1);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int len;
      req_ch.valid = 1'b0;
      req_ch.phase = '0;
      req_ch.last  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single phases at quadrant edges, extremes and two interior points give full coherence
      send_word(16'h0000, 1'b1);
      send_word(16'h4000, 1'b1);
      send_word(16'h8000, 1'b1);
      send_word(16'hC000, 1'b1);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0001, 1'b1);
      send_word(16'h5555, 1'b1);
      send_word(16'hAAAA, 1'b1);
      // opposing phases cancel
      send_word(16'h0000, 1'b0);
      send_word(16'h8000, 1'b1);
      send_word(16'h4000, 1'b0);
      send_word(16'hC000, 1'b1);
      // a quarter turn apart
      send_word(16'h2000, 1'b0);
      send_word(16'h6000, 1'b0);
      send_word(16'h3FFF, 1'b1);
      send_run(6, 16'h0000, -1);
      drain_results();

      // one long clustered run with no sender gaps
      idle_on = 1'b0;
      send_run(300, 16'h1234, 300);
      idle_on = 1'b1;

      // hold the receiver off while the sender keeps offering
      rsp_hold = 3000;
      for (int r = 0; r < 40; r++) send_run($urandom_range(4, 1), 16'h0000, -1);
      drain_results();

      for (int r = 0; words_sent < 1500; r++) begin
         idle_on = !(r >= 60 && r < 100);
         case ($urandom_range(9))
            0, 1, 2: len = 1;
            3, 4, 5, 6: len = $urandom_range(16, 2);
            default: len = $urandom_range(120, 17);
         endcase
         if ($urandom_range(1)) send_run(len, PHASE_W'($urandom), $urandom_range(2000));
         else send_run(len, 16'h0000, -1);
         if (r == 30) drain_results();
      end
      drain_results();

      $display("sent %0d phase words, checked %0d coherence results,", words_sent,
               results_seen);
      $display("including single, cancelling and long runs and a long receiver stall");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
